### sv/enq_frame_receiver_sum_check_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the frame receiver
// Checks are clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ENQ_FRAME_RECEIVER_SUM_CHECK_MACROS_SVH
`define ENQ_FRAME_RECEIVER_SUM_CHECK_MACROS_SVH

// same-cycle implication
`define EFRSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EFRSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/efrsc_pkg.sv
// ----------------------------------------------------------------------------
// efrsc_pkg
// Shared types, codes and reset values of the frame receiver.
// ----------------------------------------------------------------------------
package efrsc_pkg;

  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_TAKEN   = 3'd1;
  localparam logic [2:0] EV_ACKED   = 3'd2;
  localparam logic [2:0] EV_PENDING = 3'd3;
  localparam logic [2:0] EV_BADSUM  = 3'd4;
  localparam logic [2:0] EV_BADLEN  = 3'd5;
  localparam logic [2:0] EV_TIMEOUT = 3'd6;

  localparam logic [7:0] CFG_TIMEOUT = 8'd0;
  localparam logic [7:0] CFG_START   = 8'd1;
  localparam logic [7:0] CFG_ACK     = 8'd2;
  localparam logic [7:0] CFG_NAK     = 8'd3;

  localparam logic [15:0] TIMEOUT_RST = 16'd1000;
  localparam logic [7:0]  START_RST   = 8'd5;
  localparam logic [7:0]  ACK_RST     = 8'd6;
  localparam logic [7:0]  NAK_RST     = 8'h15;
  localparam logic [7:0]  MIN_LEN     = 8'd3;

  localparam logic       REQ_BYTE = 1'b0;
  localparam logic       REQ_TICK = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
    logic       tx_pending;
  } item_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic       reply_valid;
    logic [7:0] reply_byte;
    logic [7:0] frame_header;
    logic [7:0] frame_length;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
  } res_t;

endpackage

### sv/efrsc_in_reg.sv
// ----------------------------------------------------------------------------
// efrsc_in_reg
// Input request register; holds one request until the core takes it.
// ----------------------------------------------------------------------------
module efrsc_in_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  efrsc_pkg::item_t     in_item,
  output logic                 s1_valid,
  output efrsc_pkg::item_t     s1_item
);

  logic             valid_r;
  efrsc_pkg::item_t item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

### sv/efrsc_core.sv
// ----------------------------------------------------------------------------
// efrsc_core
// Config registers, frame state and the per-request decode logic.
// ----------------------------------------------------------------------------
module efrsc_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_index,
  input  logic [15:0]      cfg_data,
  input  logic             fire,
  input  efrsc_pkg::item_t item,
  output efrsc_pkg::res_t  res
);

  logic [15:0] timeout_r;
  logic [7:0]  start_r, ack_r, nak_r;

  logic [7:0]  count_r, count_nxt;
  logic [7:0]  header_r, header_nxt;
  logic [7:0]  length_r, length_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [15:0] idle_r, idle_nxt;
  logic [16:0] idle_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= efrsc_pkg::TIMEOUT_RST;
      start_r   <= efrsc_pkg::START_RST;
      ack_r     <= efrsc_pkg::ACK_RST;
      nak_r     <= efrsc_pkg::NAK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        efrsc_pkg::CFG_TIMEOUT: timeout_r <= cfg_data;
        efrsc_pkg::CFG_START:   start_r   <= cfg_data[7:0];
        efrsc_pkg::CFG_ACK:     ack_r     <= cfg_data[7:0];
        efrsc_pkg::CFG_NAK:     nak_r     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign idle_inc = {1'b0, idle_r} + 17'd1;

  always_comb begin
    count_nxt  = count_r;
    header_nxt = header_r;
    length_nxt = length_r;
    sum_nxt    = sum_r;
    idle_nxt   = idle_r;
    res        = '0;
    res.event_res = efrsc_pkg::EV_NONE;

    if (item.req_type == efrsc_pkg::REQ_TICK) begin
      if (idle_inc >= {1'b0, timeout_r}) begin
        idle_nxt = '0;
        if (count_r != 8'd0) begin
          res.event_res = efrsc_pkg::EV_TIMEOUT;
          count_nxt     = '0;
        end
      end else begin
        idle_nxt = idle_inc[15:0];
      end
    end else begin
      idle_nxt = '0;
      if (count_r == 8'd0) begin
        if (item.rx_byte == start_r) begin
          count_nxt     = 8'd1;
          sum_nxt       = '0;
          header_nxt    = '0;
          length_nxt    = '0;
          res.event_res = efrsc_pkg::EV_TAKEN;
        end
      end else if (count_r == 8'd1) begin
        header_nxt    = item.rx_byte;
        sum_nxt       = item.rx_byte;
        count_nxt     = 8'd2;
        res.event_res = efrsc_pkg::EV_TAKEN;
      end else if (count_r == 8'd2) begin
        length_nxt = item.rx_byte;
        if (item.rx_byte < efrsc_pkg::MIN_LEN) begin
          res.event_res = efrsc_pkg::EV_BADLEN;
          count_nxt     = '0;
        end else begin
          sum_nxt       = sum_r + item.rx_byte;
          count_nxt     = 8'd3;
          res.event_res = efrsc_pkg::EV_TAKEN;
        end
      end else if (count_r == length_r) begin
        if (sum_r == item.rx_byte) begin
          if (item.tx_pending) begin
            res.event_res = efrsc_pkg::EV_PENDING;
          end else begin
            res.event_res   = efrsc_pkg::EV_ACKED;
            res.reply_valid = 1'b1;
            res.reply_byte  = ack_r;
          end
        end else begin
          res.event_res   = efrsc_pkg::EV_BADSUM;
          res.reply_valid = 1'b1;
          res.reply_byte  = nak_r;
        end
        count_nxt = '0;
      end else begin
        res.payload_valid = 1'b1;
        res.payload_byte  = item.rx_byte;
        res.payload_index = count_r - efrsc_pkg::MIN_LEN;
        sum_nxt           = sum_r + item.rx_byte;
        count_nxt         = count_r + 8'd1;
        res.event_res     = efrsc_pkg::EV_TAKEN;
      end
    end

    res.frame_header = header_nxt;
    res.frame_length = length_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      header_r <= '0;
      length_r <= '0;
      sum_r    <= '0;
      idle_r   <= '0;
    end else if (fire) begin
      count_r  <= count_nxt;
      header_r <= header_nxt;
      length_r <= length_nxt;
      sum_r    <= sum_nxt;
      idle_r   <= idle_nxt;
    end
  end

endmodule

### sv/efrsc_out_reg.sv
// ----------------------------------------------------------------------------
// efrsc_out_reg
// Result register toward the consumer.
// ----------------------------------------------------------------------------
module efrsc_out_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            s1_valid,
  input  efrsc_pkg::res_t res,
  output logic            out_valid,
  output efrsc_pkg::res_t out_res
);

  logic            valid_r;
  efrsc_pkg::res_t res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

### sv/enq_frame_receiver_sum_check.sv
// ----------------------------------------------------------------------------
// enq_frame_receiver_sum_check: serial frame receiver with additive checksum
// Each accepted request passes the input reg, the decode logic, then the result reg.
// Throughput: 1 request per cycle through the single decode stage while out_stall is low.
// Reset: synchronous active-low rst_n; frame state to zero, config to defaults.
// ----------------------------------------------------------------------------
`include "enq_frame_receiver_sum_check_macros.svh"

module enq_frame_receiver_sum_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_tx_pending,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_event_res,
  output logic        out_reply_valid,
  output logic [7:0]  out_reply_byte,
  output logic [7:0]  out_frame_header,
  output logic [7:0]  out_frame_length,
  output logic        out_payload_valid,
  output logic [7:0]  out_payload_byte,
  output logic [7:0]  out_payload_index,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  efrsc_pkg::item_t in_item, s1_item;
  efrsc_pkg::res_t  core_res, out_res;
  logic             s1_valid, adv, fire;

  assign in_item.req_type   = in_req_type;
  assign in_item.rx_byte    = in_rx_byte;
  assign in_item.tx_pending = in_tx_pending;

  assign adv       = !out_valid || !out_stall;
  assign fire      = s1_valid && adv;
  assign in_stall  = s1_valid && !adv;
  assign cfg_ready = 1'b1;

  efrsc_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  efrsc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .item      (s1_item),
    .res       (core_res)
  );

  efrsc_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .s1_valid  (s1_valid),
    .res       (core_res),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_event_res     = out_res.event_res;
  assign out_reply_valid   = out_res.reply_valid;
  assign out_reply_byte    = out_res.reply_byte;
  assign out_frame_header  = out_res.frame_header;
  assign out_frame_length  = out_res.frame_length;
  assign out_payload_valid = out_res.payload_valid;
  assign out_payload_byte  = out_res.payload_byte;
  assign out_payload_index = out_res.payload_index;

  `EFRSC_ASSERT_NOW(a_reply_event, out_valid && out_reply_valid, out_event_res == efrsc_pkg::EV_ACKED || out_event_res == efrsc_pkg::EV_BADSUM, "reply without ack/nak event")
  `EFRSC_ASSERT_NOW(a_payload_event, out_valid && out_payload_valid, out_event_res == efrsc_pkg::EV_TAKEN && out_payload_index <= 8'd252, "payload byte with bad event or index")
  `EFRSC_ASSERT_NOW(a_full_stall, s1_valid && out_valid && out_stall, in_stall, "input taken while both stages full")
  `EFRSC_ASSERT_NEXT(a_fire_fills, fire, out_valid, "decoded request lost")

endmodule
